// File: rtl/bba_pkg.sv
// bba_pkg: types, constants and index helpers of the buddy block allocator
// used by the item interfaces and by buddy_block_allocator_core
package bba_pkg;

   localparam int MAX_LOG2     = 20;
   localparam int MIN_LOG2     = 10;
   localparam int HEADER_BYTES = 8;
   localparam int NLEV         = MAX_LOG2 - MIN_LOG2 + 1;
   localparam int NBLK         = 1 << (NLEV - 1);
   localparam int NIDS         = NBLK + NLEV;

   localparam int LEV_W  = $clog2(NLEV);
   localparam int BLK_W  = NLEV - 1;
   localparam int ID_W   = $clog2(NIDS);
   localparam int NODE_W = NLEV;
   localparam int REQ_W  = 21;
   localparam int SUM_W  = REQ_W + 1;
   localparam int ADDR_W = 32;

   localparam logic [LEV_W-1:0] LEV_MAX = LEV_W'(NLEV - 1);

   localparam logic REQ_ALLOC   = 1'b0;
   localparam logic REQ_RELEASE = 1'b1;

   localparam logic [1:0] STATUS_ALLOCATED = 2'd0;
   localparam logic [1:0] STATUS_FAILED    = 2'd1;
   localparam logic [1:0] STATUS_RELEASED  = 2'd2;
   localparam logic [1:0] STATUS_NULL      = 2'd3;

   localparam logic REG_REGION_BASE = 1'b0;

   typedef enum logic [5:0] {
      S_CLEAR, S_IDLE, S_DECODE, S_INIT2, S_FIN,
      S_A_LOOP, S_A_TAKE1, S_A_CHK1, S_A_TAKE2, S_A_CHK2,
      S_A_SPLIT0, S_A_SPLIT, S_A_SPLIT_ADD, S_A_DONE,
      S_R_START, S_R_LVL, S_R_LOOP, S_R_BITRD, S_R_BIT, S_R_UP, S_R_ADD, S_R_DONE,
      S_LR_TEST, S_LR_BITRD, S_LR_BIT, S_LR_A1, S_LR_A2, S_LR_A3, S_LR_B1, S_LR_B2,
      S_T_RD, S_T_CHK, S_F_RD, S_F_WR,
      S_L_ADD_RD, S_L_ADD_W1, S_L_ADD_W2, S_L_UNL_RD, S_L_UNL_WR, S_L_CLEAR
   } state_type;

   function automatic logic [ID_W-1:0] idm(input logic [ID_W-1:0] id);
      return (id < ID_W'(NIDS)) ? id : '0;
   endfunction

   function automatic logic [ID_W-1:0] head_of(input logic [LEV_W-1:0] lev);
      return ID_W'(NBLK) + ID_W'(lev);
   endfunction

   function automatic logic [NODE_W-1:0] node_of(input logic [BLK_W-1:0] blk,
                                                 input logic [LEV_W-1:0] lev);
      logic [LEV_W-1:0] sh;
      sh = LEV_MAX - lev;
      return (NODE_W'(blk) >> sh) + (NODE_W'(1) << lev) - NODE_W'(1);
   endfunction

   function automatic logic [BLK_W-1:0] blk_of(input logic [NODE_W-1:0] node,
                                               input logic [LEV_W-1:0] lev);
      logic [NODE_W-1:0] t;
      logic [LEV_W-1:0]  sh;
      sh = LEV_MAX - lev;
      t  = (node + NODE_W'(1) - (NODE_W'(1) << lev)) << sh;
      return t[BLK_W-1:0];
   endfunction

   function automatic logic [BLK_W-1:0] split_idx(input logic [NODE_W-1:0] node);
      logic [NODE_W-1:0] n1;
      n1 = node - NODE_W'(1);
      return n1[BLK_W:1];
   endfunction

endpackage

// File: rtl/bba_req_if.sv
// bba_req_if: request item channel, valid/ready handshake
// depends on bba_pkg for field widths
interface bba_req_if import bba_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              req_type;
   logic [REQ_W-1:0]  request_bytes;
   logic [ADDR_W-1:0] release_addr;

   modport source(output valid, req_type, request_bytes, release_addr, input ready);
   modport sink(input valid, req_type, request_bytes, release_addr, output ready);
endinterface

// File: rtl/bba_rsp_if.sv
// bba_rsp_if: result item channel, valid/ready handshake
// depends on bba_pkg for field widths
interface bba_rsp_if import bba_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [1:0]        status;
   logic [ADDR_W-1:0] block_addr;

   modport source(output valid, status, block_addr, input ready);
   modport sink(input valid, status, block_addr, output ready);
endinterface

// File: rtl/buddy_block_allocator_core.sv
// buddy_block_allocator_core: buddy allocator over a 2^20 byte region
// depends on bba_pkg, bba_req_if and bba_rsp_if
//
// usage: an item on req either allocates request_bytes (plus an 8 byte header) or
// releases an address handed out earlier; each item gives exactly one item on rsp
// with a status and, for a good allocation, the address after the header.
// region_base is written over the apb-style port at byte address 0; the user must
// write it only while idle, which the block does not enforce. one item is worked on
// at a time by a sequencer around one link list unit (prev/next memories, one read
// and one write per cycle each) and a split bit memory. a null, refused or early
// release goes straight to the result; the first allocation also sets up the top
// free list, and an allocation passes empty levels, lowers root levels and splits
// levels as needed; a release merges buddies as far as they are free.
// the result sits in an output register; the next item is taken while it waits,
// and the sequencer holds at its end until the receiver takes the previous one.
// reset: synchronous; afterwards a clearing pass zeroes the 1024 split bits, with
// req.ready low; configuration writes are taken throughout.
module buddy_block_allocator_core import bba_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   bba_req_if.sink            req,
   bba_rsp_if.source          rsp,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [2:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);

   // memories
   logic [ID_W-1:0]  prev_mem [NIDS];
   logic [ID_W-1:0]  next_mem [NIDS];
   logic             split_mem [NBLK];
   logic [LEV_W-1:0] lvl_mem [NBLK];

   state_type state_ff, state_in;
   state_type list_ret_ff, list_ret_in, take_ret_ff, take_ret_in;
   state_type lr_ret_ff, lr_ret_in, fl_ret_ff, fl_ret_in;

   logic [ID_W-1:0]   lh_ff, lh_in, le_ff, le_in, p_ff, p_in;
   logic [NODE_W-1:0] sb_node_ff, sb_node_in, node_ff, node_in;
   logic [LEV_W-1:0]  b_ff, b_in, want_ff, want_in, root_ff, root_in, tgt_ff, tgt_in;
   logic [BLK_W-1:0]  got_ff, got_in, clr_ff, clr_in;
   logic              took_ff, took_in, started_ff, started_in;
   logic              rtype_ff;
   logic [REQ_W-1:0]  bytes_ff;
   logic [ADDR_W-1:0] raddr_ff, base_ff;
   logic [1:0]        res_status_ff, res_status_in;
   logic [ADDR_W-1:0] res_addr_ff, res_addr_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [1:0]        rsp_status_ff;
   logic [ADDR_W-1:0] rsp_addr_ff;

   logic [ID_W-1:0]   prev_q, next_q, lk_ra, p_id, n_id;
   logic              sp_q;
   logic [LEV_W-1:0]  lvl_q, lvl_sat;
   logic              pv_we, nx_we, sp_we, lv_we;
   logic [ID_W-1:0]   pv_wa, pv_wd, nx_wa, nx_wd;
   logic [BLK_W-1:0]  sp_wa;
   logic              sp_wd;

   logic [SUM_W-1:0]  req_sum;
   logic              oversize;
   logic [LEV_W-1:0]  want_calc;
   logic [ADDR_W-1:0] rel_off;
   logic [NODE_W-1:0] node_got, node_sib, node_up, lr_root, lr_up;
   logic              load_rsp, cfg_wr;

   assign p_id     = idm(prev_q);
   assign n_id     = idm(next_q);
   assign lvl_sat  = (lvl_q > LEV_MAX) ? LEV_MAX : lvl_q;
   assign req_sum  = SUM_W'(bytes_ff) + SUM_W'(HEADER_BYTES);
   assign oversize = req_sum > (SUM_W'(1) << MAX_LOG2);
   assign rel_off  = raddr_ff - ADDR_W'(HEADER_BYTES) - base_ff;
   assign node_got = node_of(got_ff, b_ff);
   assign node_sib = ((node_ff - NODE_W'(1)) ^ NODE_W'(1)) + NODE_W'(1);
   assign node_up  = (node_ff - NODE_W'(1)) >> 1;
   assign lr_root  = (NODE_W'(1) << root_ff) - NODE_W'(1);
   assign lr_up    = (sb_node_ff - NODE_W'(1)) >> 1;
   assign lk_ra    = (state_ff == S_L_UNL_RD) ? le_ff : lh_ff;

   always_comb begin
      want_calc = LEV_MAX;
      for (int k = NLEV - 1; k >= 0; k--) begin
         if (req_sum <= (SUM_W'(1) << (MIN_LOG2 + k))) begin
            want_calc = LEV_W'(NLEV - 1 - k);
         end
      end
   end

   // configuration port
   assign pready = 1'b1;
   assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_REGION_BASE);
   assign prdata = (paddr[2] == REG_REGION_BASE) ? base_ff : '0;

   assign load_rsp = !rsp_valid_ff || rsp.ready;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR:       if (clr_ff == '1) state_in = S_IDLE;
         S_IDLE:        if (req.valid) state_in = S_DECODE;
         S_DECODE: begin
            if (rtype_ff == REQ_RELEASE) begin
               state_in = (raddr_ff == '0 || !started_ff) ? S_FIN : S_R_START;
            end else if (oversize) begin
               state_in = S_FIN;
            end else begin
               state_in = started_ff ? S_A_LOOP : S_L_CLEAR;
            end
         end
         S_INIT2:       state_in = S_L_ADD_RD;
         S_FIN:         if (load_rsp) state_in = S_IDLE;
         S_A_LOOP:      state_in = S_LR_TEST;
         S_A_TAKE1:     state_in = S_T_RD;
         S_A_CHK1: begin
            if (took_ff) state_in = S_A_SPLIT0;
            else if (b_ff != root_ff || b_ff == '0) state_in = (b_ff == '0) ? S_FIN : S_A_LOOP;
            else state_in = S_LR_TEST;
         end
         S_A_TAKE2:     state_in = S_T_RD;
         S_A_CHK2:      state_in = took_ff ? S_A_SPLIT0 : S_FIN;
         S_A_SPLIT0:    state_in = (node_got != '0) ? S_F_RD : S_A_SPLIT;
         S_A_SPLIT:     state_in = (b_ff < want_ff) ? S_F_RD : S_A_DONE;
         S_A_SPLIT_ADD: state_in = S_L_ADD_RD;
         S_A_DONE:      state_in = S_FIN;
         S_R_START:     state_in = S_R_LVL;
         S_R_LVL:       state_in = S_R_LOOP;
         S_R_LOOP:      state_in = (node_ff == '0) ? S_R_ADD : S_F_RD;
         S_R_BITRD:     state_in = S_R_BIT;
         S_R_BIT:       state_in = (sp_q || b_ff == root_ff) ? S_R_ADD : S_L_UNL_RD;
         S_R_UP:        state_in = S_R_LOOP;
         S_R_ADD:       state_in = S_L_ADD_RD;
         S_R_DONE:      state_in = S_FIN;
         S_LR_TEST:     state_in = (tgt_ff < root_ff) ? S_LR_BITRD : lr_ret_ff;
         S_LR_BITRD:    state_in = S_LR_BIT;
         S_LR_BIT:      state_in = sp_q ? S_L_ADD_RD : S_L_UNL_RD;
         S_LR_A1:       state_in = S_L_CLEAR;
         S_LR_A2:       state_in = S_L_ADD_RD;
         S_LR_A3:       state_in = S_LR_TEST;
         S_LR_B1:       state_in = S_L_CLEAR;
         S_LR_B2:       state_in = (lr_up != '0) ? S_F_RD : S_LR_TEST;
         S_T_RD:        state_in = S_T_CHK;
         S_T_CHK:       state_in = (p_id == lh_ff) ? take_ret_ff : S_L_UNL_RD;
         S_F_RD:        state_in = S_F_WR;
         S_F_WR:        state_in = fl_ret_ff;
         S_L_ADD_RD:    state_in = S_L_ADD_W1;
         S_L_ADD_W1:    state_in = S_L_ADD_W2;
         S_L_ADD_W2:    state_in = list_ret_ff;
         S_L_UNL_RD:    state_in = S_L_UNL_WR;
         S_L_UNL_WR:    state_in = list_ret_ff;
         S_L_CLEAR:     state_in = list_ret_ff;
         default:       state_in = S_IDLE;
      endcase
   end

   // datapath and memory controls
   always_comb begin
      list_ret_in = list_ret_ff;
      take_ret_in = take_ret_ff;
      lr_ret_in   = lr_ret_ff;
      fl_ret_in   = fl_ret_ff;
      lh_in       = lh_ff;
      le_in       = le_ff;
      p_in        = p_ff;
      sb_node_in  = sb_node_ff;
      node_in     = node_ff;
      b_in        = b_ff;
      want_in     = want_ff;
      root_in     = root_ff;
      tgt_in      = tgt_ff;
      got_in      = got_ff;
      clr_in      = clr_ff;
      took_in     = took_ff;
      started_in  = started_ff;
      res_status_in = res_status_ff;
      res_addr_in   = res_addr_ff;
      pv_we = 1'b0; pv_wa = le_ff; pv_wd = p_ff;
      nx_we = 1'b0; nx_wa = le_ff; nx_wd = lh_ff;
      sp_we = 1'b0; sp_wa = split_idx(sb_node_ff); sp_wd = !sp_q;
      lv_we = 1'b0;
      unique case (state_ff) inside
         S_CLEAR: begin
            sp_we  = 1'b1;
            sp_wa  = clr_ff;
            sp_wd  = 1'b0;
            clr_in = clr_ff + BLK_W'(1);
         end
         S_IDLE: ;
         S_DECODE: begin
            res_addr_in = '0;
            got_in      = rel_off[MAX_LOG2-1:MIN_LOG2];
            want_in     = want_calc;
            b_in        = want_calc;
            if (rtype_ff == REQ_RELEASE) begin
               res_status_in = (raddr_ff == '0) ? STATUS_NULL : STATUS_RELEASED;
            end else if (oversize) begin
               res_status_in = STATUS_FAILED;
            end else if (!started_ff) begin
               started_in  = 1'b1;
               root_in     = LEV_MAX;
               lh_in       = head_of(LEV_MAX);
               list_ret_in = S_INIT2;
            end
         end
         S_INIT2: begin
            le_in       = '0;
            list_ret_in = S_A_LOOP;
         end
         S_FIN: ;
         S_A_LOOP: begin
            tgt_in    = b_ff;
            lr_ret_in = S_A_TAKE1;
         end
         S_A_TAKE1, S_A_TAKE2: begin
            lh_in       = head_of(b_ff);
            take_ret_in = (state_ff == S_A_TAKE1) ? S_A_CHK1 : S_A_CHK2;
         end
         S_A_CHK1: begin
            if (!took_ff) begin
               if (b_ff != root_ff || b_ff == '0) begin
                  if (b_ff == '0) res_status_in = STATUS_FAILED;
                  else b_in = b_ff - LEV_W'(1);
               end else begin
                  tgt_in    = b_ff - LEV_W'(1);
                  lr_ret_in = S_A_TAKE2;
               end
            end
         end
         S_A_CHK2: if (!took_ff) res_status_in = STATUS_FAILED;
         S_A_SPLIT0: begin
            node_in    = node_got;
            sb_node_in = node_got;
            fl_ret_in  = S_A_SPLIT;
         end
         S_A_SPLIT: begin
            if (b_ff < want_ff) begin
               node_in    = {node_ff[NODE_W-2:0], 1'b1};
               sb_node_in = {node_ff[NODE_W-2:0], 1'b1};
               b_in       = b_ff + LEV_W'(1);
               fl_ret_in  = S_A_SPLIT_ADD;
            end
         end
         S_A_SPLIT_ADD: begin
            lh_in       = head_of(b_ff);
            le_in       = ID_W'(blk_of(node_ff + NODE_W'(1), b_ff));
            list_ret_in = S_A_SPLIT;
         end
         S_A_DONE: begin
            lv_we         = 1'b1;
            res_status_in = STATUS_ALLOCATED;
            res_addr_in   = base_ff + {{(ADDR_W-MIN_LOG2-BLK_W){1'b0}}, got_ff,
                                       {MIN_LOG2{1'b0}}} + ADDR_W'(HEADER_BYTES);
         end
         S_R_START: ;
         S_R_LVL: begin
            b_in    = lvl_sat;
            node_in = node_of(got_ff, lvl_sat);
         end
         S_R_LOOP: begin
            sb_node_in = node_ff;
            fl_ret_in  = S_R_BITRD;
         end
         S_R_BITRD: ;
         S_R_BIT: begin
            le_in       = ID_W'(blk_of(node_sib, b_ff));
            list_ret_in = S_R_UP;
         end
         S_R_UP: begin
            node_in = node_up;
            b_in    = b_ff - LEV_W'(1);
         end
         S_R_ADD: begin
            lh_in       = head_of(b_ff);
            le_in       = ID_W'(blk_of(node_ff, b_ff));
            list_ret_in = S_R_DONE;
         end
         S_R_DONE: res_status_in = STATUS_RELEASED;
         S_LR_TEST: sb_node_in = lr_root;
         S_LR_BITRD: ;
         S_LR_BIT: begin
            if (sp_q) begin
               lh_in       = head_of(root_ff);
               le_in       = ID_W'(blk_of(NODE_W'(1) << root_ff, root_ff));
               list_ret_in = S_LR_B1;
            end else begin
               le_in       = '0;
               list_ret_in = S_LR_A1;
            end
         end
         S_LR_A1, S_LR_B1: begin
            lh_in       = head_of(root_ff - LEV_W'(1));
            list_ret_in = (state_ff == S_LR_A1) ? S_LR_A2 : S_LR_B2;
         end
         S_LR_A2: begin
            le_in       = '0;
            list_ret_in = S_LR_A3;
         end
         S_LR_A3: root_in = root_ff - LEV_W'(1);
         S_LR_B2: begin
            root_in    = root_ff - LEV_W'(1);
            sb_node_in = lr_up;
            fl_ret_in  = S_LR_TEST;
         end
         S_T_RD: ;
         S_T_CHK: begin
            if (p_id == lh_ff) begin
               took_in = 1'b0;
            end else begin
               took_in     = 1'b1;
               got_in      = p_id[BLK_W-1:0];
               le_in       = p_id;
               list_ret_in = take_ret_ff;
            end
         end
         S_F_RD: ;
         S_F_WR: sp_we = 1'b1;
         S_L_ADD_RD: ;
         S_L_ADD_W1: begin
            p_in  = p_id;
            pv_we = 1'b1; pv_wa = le_ff; pv_wd = p_id;
            nx_we = 1'b1; nx_wa = le_ff; nx_wd = lh_ff;
         end
         S_L_ADD_W2: begin
            nx_we = 1'b1; nx_wa = p_ff;  nx_wd = le_ff;
            pv_we = 1'b1; pv_wa = lh_ff; pv_wd = le_ff;
         end
         S_L_UNL_RD: ;
         S_L_UNL_WR: begin
            nx_we = 1'b1; nx_wa = p_id; nx_wd = n_id;
            pv_we = 1'b1; pv_wa = n_id; pv_wd = p_id;
         end
         S_L_CLEAR: begin
            pv_we = 1'b1; pv_wa = lh_ff; pv_wd = lh_ff;
            nx_we = 1'b1; nx_wa = lh_ff; nx_wd = lh_ff;
         end
         default: ;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp.ready) rsp_valid_in = 1'b0;
      if (state_ff == S_FIN && load_rsp) rsp_valid_in = 1'b1;
   end

   assign req.ready      = (state_ff == S_IDLE);
   assign rsp.valid      = rsp_valid_ff;
   assign rsp.status     = rsp_status_ff;
   assign rsp.block_addr = rsp_addr_ff;

   // memories
   always_ff @(posedge clock) begin
      if (pv_we) prev_mem[pv_wa] <= pv_wd;
      if (nx_we) next_mem[nx_wa] <= nx_wd;
      prev_q <= prev_mem[lk_ra];
      next_q <= next_mem[lk_ra];
   end

   always_ff @(posedge clock) begin
      if (sp_we) split_mem[sp_wa] <= sp_wd;
      sp_q <= split_mem[split_idx(sb_node_ff)];
   end

   always_ff @(posedge clock) begin
      if (lv_we) lvl_mem[got_ff] <= want_ff;
      lvl_q <= lvl_mem[got_ff];
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         started_ff   <= 1'b0;
         root_ff      <= LEV_MAX;
         rsp_valid_ff <= 1'b0;
         base_ff      <= '0;
         list_ret_ff  <= S_IDLE;
         take_ret_ff  <= S_IDLE;
         lr_ret_ff    <= S_IDLE;
         fl_ret_ff    <= S_IDLE;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         started_ff   <= started_in;
         root_ff      <= root_in;
         rsp_valid_ff <= rsp_valid_in;
         list_ret_ff  <= list_ret_in;
         take_ret_ff  <= take_ret_in;
         lr_ret_ff    <= lr_ret_in;
         fl_ret_ff    <= fl_ret_in;
         if (cfg_wr) base_ff <= pwdata;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      lh_ff         <= lh_in;
      le_ff         <= le_in;
      p_ff          <= p_in;
      sb_node_ff    <= sb_node_in;
      node_ff       <= node_in;
      b_ff          <= b_in;
      want_ff       <= want_in;
      tgt_ff        <= tgt_in;
      got_ff        <= got_in;
      took_ff       <= took_in;
      res_status_ff <= res_status_in;
      res_addr_ff   <= res_addr_in;
      if (req.valid && req.ready) begin
         rtype_ff <= req.req_type;
         bytes_ff <= req.request_bytes;
         raddr_ff <= req.release_addr;
      end
      if (state_ff == S_FIN && load_rsp) begin
         rsp_status_ff <= res_status_ff;
         rsp_addr_ff   <= res_addr_ff;
      end
   end

   // checks
   a_root_range: assert property (@(posedge clock) disable iff (reset)
      root_ff <= LEV_MAX) else $error("root level out of range");

   a_root_before_start: assert property (@(posedge clock) disable iff (reset)
      !started_ff |-> root_ff == LEV_MAX) else $error("root lowered before start");

   a_rsp_from_fin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_FIN)) else $error("result outside fin");

   a_lower_needed: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_LR_BIT |-> tgt_ff < root_ff) else $error("root lowered past target");

endmodule

// File: dv/tb_bba_checker.sv
`timescale 1ns / 100ps
// tb_bba_checker: watches the request, result and register ports of the allocator,
// predicts every result item from its own copy of the free lists and compares in order
// depends on bba_pkg, bba_req_if and bba_rsp_if
module tb_bba_checker import bba_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   bba_req_if          req,
   bba_rsp_if          rsp,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic        pready,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output int          fail_count,
   output int          pending
);

   typedef struct {
      logic [1:0]  status;
      logic [31:0] addr;
   } outcome_type;

   outcome_type outcome_q[$];
   logic [31:0] base_addr;
   bit          started;
   int unsigned root_lev;
   bit          split_bit [NBLK];
   int unsigned link_prev [NIDS];
   int unsigned link_next [NIDS];
   int unsigned blk_lev [NBLK];

   function automatic int unsigned fix_id(int unsigned id);
      return (id < NIDS) ? id : 0;
   endfunction

   function automatic int unsigned head_id(int unsigned lev);
      return NBLK + lev;
   endfunction

   function automatic void list_reset(int unsigned h);
      h = fix_id(h);
      link_prev[h] = h;
      link_next[h] = h;
   endfunction

   function automatic void fl_append(int unsigned h, int unsigned e);
      int unsigned p;
      h = fix_id(h);
      e = fix_id(e);
      p = fix_id(link_prev[h]);
      link_prev[e] = p;
      link_next[e] = h;
      link_next[p] = e;
      link_prev[h] = e;
   endfunction

   function automatic void list_drop(int unsigned e);
      int unsigned p, n;
      e = fix_id(e);
      p = fix_id(link_prev[e]);
      n = fix_id(link_next[e]);
      link_next[p] = n;
      link_prev[n] = p;
   endfunction

   function automatic bit fl_take_last(int unsigned h, output int unsigned got);
      int unsigned back;
      h = fix_id(h);
      back = fix_id(link_prev[h]);
      got = 0;
      if (back == h) return 0;
      list_drop(back);
      got = back & (NBLK - 1);
      return 1;
   endfunction

   function automatic bit above_bit(int unsigned node);
      return split_bit[((node - 1) >> 1) & (NBLK - 1)];
   endfunction

   function automatic void above_flip(int unsigned node);
      split_bit[((node - 1) >> 1) & (NBLK - 1)] ^= 1'b1;
   endfunction

   function automatic int unsigned block_at(int unsigned node, int unsigned lev);
      return ((node + 1 - (1 << lev)) << (NLEV - 1 - lev)) & (NBLK - 1);
   endfunction

   function automatic int unsigned node_at(int unsigned blk, int unsigned lev);
      return ((blk & (NBLK - 1)) >> (NLEV - 1 - lev)) + (1 << lev) - 1;
   endfunction

   function automatic void lower_root_to(int unsigned lev);
      int unsigned lim, root;
      while (lev < root_lev) begin
         lim  = root_lev;
         root = (1 << lim) - 1;
         if (!above_bit(root)) begin
            list_drop(0);
            lim--;
            list_reset(head_id(lim));
            fl_append(head_id(lim), 0);
            root_lev = lim;
            continue;
         end
         fl_append(head_id(lim), block_at(root + 1, lim));
         lim--;
         list_reset(head_id(lim));
         root_lev = lim;
         root = (root - 1) >> 1;
         if (root != 0) above_flip(root);
      end
   endfunction

   function automatic bit grant_block(logic [REQ_W-1:0] nbytes, output logic [31:0] addr);
      longint unsigned need, size;
      int want, lev;
      int unsigned got, node;
      need = longint'(nbytes) + HEADER_BYTES;
      size = 64'd1 << MIN_LOG2;
      want = NLEV - 1;
      addr = '0;
      if (need > (64'd1 << MAX_LOG2)) return 0;
      if (!started) begin
         started  = 1;
         root_lev = NLEV - 1;
         list_reset(head_id(NLEV - 1));
         fl_append(head_id(NLEV - 1), 0);
      end
      while (size < need && want > 0) begin
         want--;
         size <<= 1;
      end
      lev = want;
      while (lev >= 0) begin
         lower_root_to(lev);
         if (!fl_take_last(head_id(lev), got)) begin
            if (lev != root_lev || lev == 0) begin
               lev--;
               continue;
            end
            lower_root_to(lev - 1);
            if (!fl_take_last(head_id(lev), got)) return 0;
         end
         node = node_at(got, lev);
         if (node != 0) above_flip(node);
         while (lev < want) begin
            node = node * 2 + 1;
            lev++;
            above_flip(node);
            fl_append(head_id(lev), block_at(node + 1, lev));
         end
         blk_lev[got] = want;
         addr = base_addr + (got << MIN_LOG2) + HEADER_BYTES;
         return 1;
      end
      return 0;
   endfunction

   function automatic void return_block(logic [31:0] addr);
      logic [31:0] off;
      int unsigned blk, lev, node;
      off  = (addr - HEADER_BYTES - base_addr) & ((32'd1 << MAX_LOG2) - 1);
      blk  = (off >> MIN_LOG2) & (NBLK - 1);
      lev  = blk_lev[blk];
      if (lev > NLEV - 1) lev = NLEV - 1;
      node = node_at(blk, lev);
      while (node != 0) begin
         above_flip(node);
         if (above_bit(node) || lev == root_lev) break;
         list_drop(block_at(((node - 1) ^ 1) + 1, lev));
         node = (node - 1) >> 1;
         lev--;
      end
      fl_append(head_id(lev), block_at(node, lev));
   endfunction

   function automatic outcome_type predict_outcome(logic kind, logic [REQ_W-1:0] nbytes,
                                                   logic [31:0] raddr);
      outcome_type o;
      o.addr = '0;
      if (kind == REQ_ALLOC) begin
         o.status = grant_block(nbytes, o.addr) ? STATUS_ALLOCATED : STATUS_FAILED;
         if (o.status != STATUS_ALLOCATED) o.addr = '0;
      end else if (raddr == '0) begin
         o.status = STATUS_NULL;
      end else begin
         if (started) return_block(raddr);
         o.status = STATUS_RELEASED;
      end
      return o;
   endfunction

   always @(posedge clock) begin
      outcome_type want;
      if (reset) begin
         outcome_q.delete();
         fail_count = 0;
         base_addr  = '0;
         started    = 0;
         root_lev   = NLEV - 1;
         foreach (split_bit[k]) split_bit[k] = 0;
         foreach (link_prev[k]) begin
            link_prev[k] = 0;
            link_next[k] = 0;
         end
         foreach (blk_lev[k]) blk_lev[k] = 0;
      end else begin
         if (psel && penable && pwrite && pready && paddr == {REG_REGION_BASE, 2'b00})
            base_addr = pwdata;
         if (rsp.valid && rsp.ready) begin
            if (outcome_q.size() == 0) begin
               $error("result item with nothing expected: status %0d addr %h",
                      rsp.status, rsp.block_addr);
               fail_count++;
            end else begin
               want = outcome_q.pop_front();
               if (rsp.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp.status);
                  fail_count++;
               end
               if (rsp.block_addr !== want.addr) begin
                  $error("block_addr: expected %h, got %h", want.addr, rsp.block_addr);
                  fail_count++;
               end
            end
         end
         if (req.valid && req.ready)
            outcome_q.push_back(predict_outcome(req.req_type, req.request_bytes,
                                                req.release_addr));
      end
      pending = outcome_q.size();
   end

endmodule

// File: dv/tb_buddy_block_allocator_core.sv
`timescale 1ns / 100ps
// tb_buddy_block_allocator_core: drives allocate and release items and region_base
// writes into the allocator; checking is done by tb_bba_checker
// depends on bba_pkg, bba_req_if, bba_rsp_if, tb_bba_checker and the core
module tb_buddy_block_allocator_core;
   import bba_pkg::*;

   logic        clock;
   logic        reset;
   logic        psel, penable, pwrite;
   logic [2:0]  paddr;
   logic [31:0] pwdata, prdata;
   logic        pready;
   int          fail_count, pending;

   bit          idle_on;
   bit          hold_req;
   int          hold_cnt;
   int          quiet = 0;
   logic [31:0] cur_base;
   int unsigned live_q[$];
   int          n_ok = 0, n_fail = 0, n_rel = 0, n_null = 0;

   bba_req_if req ();
   bba_rsp_if rsp ();

   buddy_block_allocator_core dut (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   tb_bba_checker checker_i (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp),
      .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
      .paddr(paddr), .pwdata(pwdata), .fail_count(fail_count), .pending(pending)
   );

   initial begin
      clock = 0;
      forever #4 clock = ~clock;
   end

   // receiver: random stalls, plus one long hold-off on request
   initial begin
      bit hold_done;
      hold_done = 0;
      rsp.ready = 0;
      hold_cnt  = 0;
      forever begin
         @(negedge clock);
         if (hold_req && !hold_done) begin
            hold_done = 1;
            hold_cnt  = 600;
         end
         if (hold_cnt > 0) begin
            hold_cnt--;
            rsp.ready = 0;
         end else begin
            rsp.ready = idle_on ? ($urandom_range(0, 99) >= 32) : 1'b1;
         end
      end
   end

   // collect granted offsets so that later releases name live blocks
   always @(posedge clock) begin
      if (!reset && rsp.valid && rsp.ready) begin
         case (rsp.status)
            STATUS_ALLOCATED: begin
               n_ok++;
               live_q.push_back((rsp.block_addr - cur_base - HEADER_BYTES) & 32'hFFFFF);
            end
            STATUS_FAILED: n_fail++;
            STATUS_RELEASED: n_rel++;
            default: n_null++;
         endcase
      end
   end

   always @(posedge clock) begin
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || psel) quiet = 0;
      else quiet++;
      if (quiet >= 20000) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   task automatic reg_write(logic [31:0] value);
      @(negedge clock);
      psel = 1; penable = 0; pwrite = 1; paddr = {REG_REGION_BASE, 2'b00}; pwdata = value;
      @(negedge clock);
      penable = 1;
      @(negedge clock);
      psel = 0; penable = 0; pwrite = 0;
      cur_base = value;
   endtask

   task automatic send_item(logic kind, logic [REQ_W-1:0] nbytes, logic [31:0] raddr);
      int gap;
      @(negedge clock);
      if (idle_on && $urandom_range(0, 99) < 32) begin
         gap = $urandom_range(1, 4);
         req.valid = 0;
         repeat (gap) @(negedge clock);
      end
      req.req_type      = kind;
      req.request_bytes = nbytes;
      req.release_addr  = raddr;
      req.valid         = 1;
      do @(posedge clock); while (!req.ready);
   endtask

   task automatic drain();
      @(negedge clock);
      req.valid = 0;
      do @(negedge clock); while (pending != 0);
   endtask

   task automatic alloc_item(logic [REQ_W-1:0] nbytes);
      send_item(REQ_ALLOC, nbytes, $urandom);
   endtask

   // release a live block, sometimes by an inner or aliased address
   task automatic release_live();
      int k;
      logic [31:0] a;
      k = $urandom_range(0, live_q.size() - 1);
      a = cur_base + live_q[k] + HEADER_BYTES;
      live_q.delete(k);
      if ($urandom_range(0, 3) == 0) a += $urandom_range(0, 1015);
      if ($urandom_range(0, 3) == 0) a += $urandom << MAX_LOG2;
      send_item(REQ_RELEASE, REQ_W'($urandom), a);
   endtask

   task automatic random_items(int count);
      int lev;
      logic [REQ_W-1:0] nb;
      repeat (count) begin
         case ($urandom_range(0, 19))
            0: send_item(REQ_RELEASE, REQ_W'($urandom), 32'd0);
            1: alloc_item(REQ_W'($urandom_range(1048569, 2097151)));
            2, 3, 4, 5, 6, 7, 8, 9, 10: begin
               lev = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 10)
                                                 : $urandom_range(0, 3);
               nb = REQ_W'($urandom_range(0, (1024 << lev) - HEADER_BYTES));
               alloc_item(nb);
            end
            default: begin
               if (live_q.size() > 0) release_live();
               else alloc_item(REQ_W'($urandom_range(0, 4000)));
            end
         endcase
      end
      drain();
   endtask

   initial begin
      reset = 1; psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
      req.valid = 0; req.req_type = REQ_ALLOC; req.request_bytes = '0;
      req.release_addr = '0;
      idle_on = 0; hold_req = 0; cur_base = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 0;

      reg_write(32'hFFFF_FFFF);
      send_item(REQ_RELEASE, '0, 32'd0);
      send_item(REQ_RELEASE, '1, 32'hDEAD_BEEF);
      alloc_item(21'h1F_FFFF);
      alloc_item(21'd1048576);
      alloc_item(21'd1048568);
      alloc_item(21'd0);
      drain();
      release_live();
      alloc_item(21'd0);
      alloc_item(21'd1016);
      alloc_item(21'd1017);
      alloc_item(21'd5000);
      alloc_item(21'd300000);
      alloc_item(21'd600000);
      drain();
      while (live_q.size() > 0) release_live();
      alloc_item(21'd1048568);
      send_item(REQ_RELEASE, '0, 32'd0);
      drain();
      while (live_q.size() > 0) release_live();
      drain();

      repeat (200) @(negedge clock);
      reg_write($urandom);
      idle_on = 1;
      random_items(300);
      hold_req = 1;
      random_items(300);

      repeat (200) @(negedge clock);
      reg_write(32'd0);
      idle_on = 0;
      random_items(600);

      repeat (200) @(negedge clock);
      reg_write($urandom);
      idle_on = 1;
      random_items(600);

      repeat (200) @(negedge clock);
      $display("items back: %0d granted, %0d refused, %0d released, %0d null releases",
               n_ok, n_fail, n_rel, n_null);
      $display("region_base swept over zero, all-ones and random values");
      if (fail_count == 0 && pending == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

// File: files.f
rtl/bba_pkg.sv
rtl/bba_req_if.sv
rtl/bba_rsp_if.sv
rtl/buddy_block_allocator_core.sv
dv/tb_bba_checker.sv
dv/tb_buddy_block_allocator_core.sv
